### src/scsa_pkg.sv
package scsa_pkg;

    // Arena geometry.
    localparam int NUM_CLASSES   = 6;
    localparam int SLAB_BYTES    = 1024;
    localparam int ARENA_BYTES   = 65536;
    localparam int GRANULE_BYTES = 8;

    localparam int MAX_FRAMES = ARENA_BYTES / SLAB_BYTES;
    localparam int GRANULES   = ARENA_BYTES / GRANULE_BYTES;
    localparam int GRAN_SH    = $clog2(GRANULE_BYTES);
    localparam int SLAB_SH    = $clog2(SLAB_BYTES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int FCNT_W     = FRAME_W + 1;
    localparam int GIDX_W     = $clog2(GRANULES);
    localparam int ADDR_W     = 16;
    localparam int BADDR_W    = $clog2(ARENA_BYTES) + 1;
    localparam int LINK_W     = ADDR_W + 1;
    localparam int SLAB_G     = SLAB_BYTES / GRANULE_BYTES;
    localparam int DIV_W      = $clog2(SLAB_G) + 1;
    localparam int CELLB_W    = DIV_W + GRAN_SH;
    localparam int CLASS_W    = 3;
    localparam int REG_W      = 9;
    localparam int IDX_W      = 3;
    localparam int LIVE_W     = 14;
    localparam int CNT_W      = 32;

    typedef logic [REG_W-1:0] csize_t;
    typedef logic [DIV_W-1:0] cellg_t;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_OVERSIZE  = 2'd2;

    localparam csize_t CLASS_RESET [8] = '{9'd16, 9'd32, 9'd48, 9'd64,
                                           9'd128, 9'd256, 9'd256, 9'd256};

    // Effective cell size in granules: rounded down to a granule, at least
    // one granule, at most a whole slab.
    function automatic cellg_t cell_g(input csize_t sz);
        logic [REG_W-1:0] v;
        v = sz >> GRAN_SH;
        if (v == '0) v = REG_W'(1);
        if (32'(v) > SLAB_G) v = REG_W'(SLAB_G);
        return v[DIV_W-1:0];
    endfunction

endpackage

### src/size_class_slab_allocator.sv
// Segregated-fit slab allocator for a 64 KiB arena cut into 1 KiB slab frames.
//
// Requests come in on the s_ stream channel, one word per request: allocate,
// free or ownership query. Each request produces exactly one result word on
// the m_ channel with a status, the granted address, the query answer and the
// live and total allocation counters as they stand after the request. The user
// must write size-class cell sizes through the cfg_ port only while the block is
// idle; the block does not enforce this. They take effect with the next request.
//
// From acceptance to its result being registered, a request passes through
// these steps: the class is picked while the frame-owner memory read, started
// at acceptance, lands; the iterative remainder unit (eight quotient steps and
// a final step to hand the remainder over) checks cell alignment and slab
// fill; the link/liveness memory is read, then read-modify-written. s_tready
// rises again in the same cycle as m_tvalid, so a new request is accepted only
// once the previous one has its result registered.
//
// After reset the liveness/link memory is swept to zero, one entry per cycle,
// over all of its entries; s_tready stays low until the sweep is done. Config
// writes are taken during the sweep. If the receiver stalls, the result word
// is held and the next request may be accepted and worked on, but it waits
// before its memory write until the held word is taken.
module size_class_slab_allocator import scsa_pkg::*; #(
    parameter int IN_W  = 32,
    parameter int OUT_W = 72
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_wdata,
    // Request channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // mode[1:0], request_bytes[10:2], cell_address[26:11]
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // status[1:0], granted_address[17:2], owned[18],
                                         // live_cells[32:19], total_allocations[64:33]
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_PREP, S_DIV, S_READ, S_EXEC} state_t;

    state_t state_reg;

    csize_t class_size_reg [NUM_CLASSES];
    logic [LINK_W-1:0]  free_head_reg  [NUM_CLASSES];
    logic [BADDR_W-1:0] bump_next_reg  [NUM_CLASSES];
    logic [BADDR_W-1:0] bump_limit_reg [NUM_CLASSES];
    logic [FCNT_W-1:0]  frames_reg;
    logic [LIVE_W-1:0]  live_reg;
    logic [CNT_W-1:0]   alloc_reg;
    logic [GIDX_W:0]    clr_cnt_reg;

    // Request held while it is worked on.
    logic [1:0]         mode_reg;
    logic [REG_W-1:0]   bytes_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic               cls_ok_reg;
    logic [CLASS_W-1:0] fc_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [BADDR_W-1:0] granted_reg;
    logic               pop_reg;
    logic               claim_reg;
    logic               exh_reg;
    logic [BADDR_W-1:0] limit_new_reg;

    // Result word.
    logic               m_tvalid_reg;
    logic [1:0]         out_status_reg;
    logic [ADDR_W-1:0]  out_granted_reg;
    logic               out_owned_reg;

    // Input fields.
    logic [1:0]         in_mode;
    logic [REG_W-1:0]   in_bytes;
    logic [ADDR_W-1:0]  in_addr;
    assign in_mode  = s_tdata[1:0];
    assign in_bytes = s_tdata[10:2];
    assign in_addr  = s_tdata[26:11];

    // Class choice: first class whose cell holds the request.
    logic [CLASS_W-1:0] pick_cls;
    logic               pick_ok;
    always_comb begin
        pick_cls = '0;
        pick_ok  = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (!pick_ok && ({{(CELLB_W-REG_W){1'b0}}, bytes_reg} <=
                             {cell_g(class_size_reg[i]), {GRAN_SH{1'b0}}})) begin
                pick_cls = CLASS_W'(i);
                pick_ok  = 1'b1;
            end
        end
    end

    logic [CLASS_W-1:0] fc_rdata;
    logic               fc_we;
    scsa_ram #(.WIDTH(CLASS_W), .DEPTH(MAX_FRAMES)) u_frame_ram (
        .aclk  (aclk),
        .we    (fc_we),
        .waddr (frames_reg[FRAME_W-1:0]),
        .wdata (cls_reg),
        .raddr (in_addr[ADDR_W-1:SLAB_SH]),
        .rdata (fc_rdata)
    );

    // Remainder unit: SLAB % cell for an allocation, offset % cell otherwise.
    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_rem;
    logic [DIV_W-1:0] div_num;
    cellg_t           div_den;
    assign div_start = (state_reg == S_PREP);
    assign div_num = (mode_reg == MODE_ALLOC) ? DIV_W'(SLAB_G)
                   : DIV_W'(addr_reg[SLAB_SH-1:GRAN_SH]);
    assign div_den = (mode_reg == MODE_ALLOC) ? cell_g(class_size_reg[pick_cls])
                   : cell_g(class_size_reg[fc_rdata[CLASS_W-1:0]]);

    scsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Allocation decision, made in the read state.
    logic [LINK_W-1:0]  cur_head;
    logic [BADDR_W-1:0] cur_next;
    logic [BADDR_W-1:0] cur_limit;
    logic [BADDR_W-1:0] claim_base;
    logic               rd_pop;
    logic               rd_claim;
    logic               rd_exh;
    logic [BADDR_W-1:0] rd_granted;
    logic [GIDX_W-1:0]  rd_gidx;
    assign cur_head   = free_head_reg[cls_reg];
    assign cur_next   = bump_next_reg[cls_reg];
    assign cur_limit  = bump_limit_reg[cls_reg];
    assign claim_base = BADDR_W'(frames_reg) << SLAB_SH;
    always_comb begin
        rd_pop     = cur_head[LINK_W-1];
        rd_claim   = 1'b0;
        rd_exh     = 1'b0;
        rd_granted = cur_next;
        if (rd_pop) begin
            rd_granted = BADDR_W'(cur_head[ADDR_W-1:0]);
        end else if (cur_next >= cur_limit) begin
            if (32'(frames_reg) >= MAX_FRAMES) begin
                rd_exh = 1'b1;
            end else begin
                rd_claim   = 1'b1;
                rd_granted = claim_base;
            end
        end
        rd_gidx = (mode_reg == MODE_ALLOC) ? rd_granted[GRAN_SH+GIDX_W-1:GRAN_SH]
                                           : addr_reg[GRAN_SH+GIDX_W-1:GRAN_SH];
    end

    // Liveness and link memory: {live, link}.
    logic                gm_we;
    logic [GIDX_W-1:0]   gm_waddr;
    logic [LINK_W:0]     gm_wdata;
    logic [LINK_W:0]     gm_rdata;
    scsa_ram #(.WIDTH(LINK_W + 1), .DEPTH(GRANULES)) u_gran_ram (
        .aclk  (aclk),
        .we    (gm_we),
        .waddr (gm_waddr),
        .wdata (gm_wdata),
        .raddr (rd_gidx),
        .rdata (gm_rdata)
    );

    // Execute-state decisions.
    logic               out_free;
    logic               exec_go;
    cellg_t             cls_cellg;
    cellg_t             fc_cellg;
    logic               owned_chk;
    logic               rd_live;
    logic [CELLB_W-1:0] cls_cellb;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_go   = (state_reg == S_EXEC) && out_free;
    assign rd_live   = gm_rdata[LINK_W];
    assign cls_cellg = cell_g(class_size_reg[cls_reg]);
    assign fc_cellg  = cell_g(class_size_reg[fc_reg]);
    assign cls_cellb = {cls_cellg, {GRAN_SH{1'b0}}};
    // The address must sit in a claimed frame, on a granule, on a cell boundary
    // and inside the whole cells of its slab, and the cell must be live.
    assign owned_chk = ({1'b0, addr_reg[ADDR_W-1:SLAB_SH]} < frames_reg)
                     && (addr_reg[GRAN_SH-1:0] == '0)
                     && (rem_reg == '0)
                     && ((32'(addr_reg[SLAB_SH-1:GRAN_SH]) + 32'(fc_cellg)) <= SLAB_G)
                     && rd_live;

    logic do_alloc;
    logic do_free;
    assign do_alloc = (mode_reg == MODE_ALLOC) && cls_ok_reg && !exh_reg;
    assign do_free  = (mode_reg == MODE_FREE) && cls_ok_reg && owned_chk
                    && (fc_reg == cls_reg);
    assign fc_we    = exec_go && do_alloc && claim_reg;

    always_comb begin
        gm_we    = 1'b0;
        gm_waddr = addr_reg[GRAN_SH+GIDX_W-1:GRAN_SH];
        gm_wdata = '0;
        if (state_reg == S_CLR) begin
            gm_we    = 1'b1;
            gm_waddr = clr_cnt_reg[GIDX_W-1:0];
        end else if (exec_go && do_alloc) begin
            gm_we    = 1'b1;
            gm_waddr = granted_reg[GRAN_SH+GIDX_W-1:GRAN_SH];
            gm_wdata = {1'b1, gm_rdata[LINK_W-1:0]};
        end else if (exec_go && do_free) begin
            gm_we    = 1'b1;
            gm_wdata = {1'b0, free_head_reg[cls_reg]};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-65){1'b0}}, alloc_reg, live_reg, out_owned_reg,
                       out_granted_reg, out_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            frames_reg   <= '0;
            live_reg     <= '0;
            alloc_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                class_size_reg[i] <= CLASS_RESET[i];
                free_head_reg[i]  <= '0;
                bump_next_reg[i]  <= '0;
                bump_limit_reg[i] <= '0;
            end
        end else begin
            if (cfg_we && (32'(cfg_index) < NUM_CLASSES)) begin
                class_size_reg[cfg_index] <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + (GIDX_W+1)'(1);
                    if (clr_cnt_reg == (GIDX_W+1)'(GRANULES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= in_mode;
                        bytes_reg <= in_bytes;
                        addr_reg  <= in_addr;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    fc_reg     <= fc_rdata[CLASS_W-1:0];
                    cls_reg    <= pick_cls;
                    cls_ok_reg <= pick_ok;
                    state_reg  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        rem_reg   <= div_rem;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    pop_reg       <= rd_pop;
                    claim_reg     <= rd_claim;
                    exh_reg       <= rd_exh;
                    granted_reg   <= rd_granted;
                    limit_new_reg <= claim_base
                                   + BADDR_W'({DIV_W'(SLAB_G) - rem_reg, {GRAN_SH{1'b0}}});
                    state_reg     <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_tvalid_reg    <= 1'b1;
                        out_status_reg  <= ST_OK;
                        out_granted_reg <= '0;
                        out_owned_reg   <= 1'b0;
                        state_reg       <= S_IDLE;
                        case (mode_reg)
                            MODE_ALLOC: begin
                                if (!cls_ok_reg) begin
                                    out_status_reg <= ST_OVERSIZE;
                                end else if (exh_reg) begin
                                    out_status_reg <= ST_EXHAUSTED;
                                end else begin
                                    out_granted_reg <= granted_reg[ADDR_W-1:0];
                                    alloc_reg       <= alloc_reg + CNT_W'(1);
                                    if (!rd_live) begin
                                        live_reg <= live_reg + LIVE_W'(1);
                                    end
                                    if (pop_reg) begin
                                        free_head_reg[cls_reg] <= gm_rdata[LINK_W-1:0];
                                    end else begin
                                        bump_next_reg[cls_reg] <= granted_reg
                                                                + BADDR_W'(cls_cellb);
                                        if (claim_reg) begin
                                            bump_limit_reg[cls_reg] <= limit_new_reg;
                                            frames_reg <= frames_reg + FCNT_W'(1);
                                        end
                                    end
                                end
                            end
                            MODE_FREE: begin
                                if (!cls_ok_reg) begin
                                    out_status_reg <= ST_OVERSIZE;
                                end else if (do_free) begin
                                    live_reg <= live_reg - LIVE_W'(1);
                                    free_head_reg[cls_reg] <= {1'b1, addr_reg};
                                end
                            end
                            MODE_QUERY: begin
                                out_owned_reg <= owned_chk;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/scsa_ram.sv
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/scsa_div.sv
module scsa_div import scsa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] rem
);

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    trial;

    assign trial = {rem_reg, num_reg[DIV_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= DIV_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DIV_W-1:0];
            end
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = !busy_reg && (step_reg == STEP_W'(DIV_W));
    assign rem  = rem_reg;

endmodule

### src/scsa_checker.sv
module scsa_checker import scsa_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A held result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No result is pending right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A failed request grants nothing and answers no query.
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[18:2] == '0))
        else $error("failed request carries an address or ownership");

    // Every result reports a defined status and a live count within the arena.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (32'(m_tdata[32:19]) <= GRANULES))
        else $error("status or live count out of range");

    // A request is not taken back to back with the one before.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb_top.sv
// Testbench for the segregated-fit slab allocator.
//
// Requests are driven on the s_ stream channel at the falling clock edge, and
// handshakes and results are sampled at the rising edge. A behavioral copy of
// the allocator runs beside the block. It holds its own free lists, bump
// pointers, frame owners, link and liveness stores, counters and size-class
// registers. Each accepted request word is run through it, and the expected
// result word is queued. Every result word taken from the m_ channel is
// compared field by field with the oldest queued expectation.
//
// The sender works in bursts with random gaps. The receiver stalls at random
// with a stall rate that is redrawn periodically, and some stretches have no
// stalls at all. Size-class registers are rewritten only between phases, once
// every result has come back and the pipeline has had time to settle.
module tb_top;
    import scsa_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 30;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted;
        logic              owned;
        logic [LIVE_W-1:0] live;
        logic [CNT_W-1:0]  total;
    } alloc_result_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  bytes;
    } held_cell_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // mode[1:0], request_bytes[10:2], cell_address[26:11]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [71:0]       m_tdata;    // status[1:0], granted_address[17:2], owned[18],
                                   // live_cells[32:19], total_allocations[64:33]

    size_class_slab_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // The allocator state as the testbench sees it.
    logic [REG_W-1:0]   size_reg   [NUM_CLASSES];
    logic               head_ok    [NUM_CLASSES];
    logic [ADDR_W-1:0]  head_addr  [NUM_CLASSES];
    logic [BADDR_W-1:0] bump_ptr   [NUM_CLASSES];
    logic [BADDR_W-1:0] bump_end   [NUM_CLASSES];
    logic [FCNT_W-1:0]  frame_cnt;
    logic [CLASS_W-1:0] frame_owner [MAX_FRAMES];
    logic               link_ok    [GRANULES];
    logic [ADDR_W-1:0]  link_addr  [GRANULES];
    logic               live_bit   [GRANULES];
    logic [LIVE_W-1:0]  live_count;
    logic [CNT_W-1:0]   grant_count;

    alloc_result_t pending_results[$];
    held_cell_t    held_cells[$];
    int            mismatches;
    int            cycles = 0;
    int            burst_left;
    int            stall_pct = 0;

    // Effective cell size in bytes: rounded down to a granule, at least one
    // granule. A 9-bit register can never exceed a whole slab.
    function automatic int cell_size(int c);
        int v;
        v = (int'(size_reg[c]) / GRANULE_BYTES) * GRANULE_BYTES;
        if (v < GRANULE_BYTES) v = GRANULE_BYTES;
        return v;
    endfunction

    // First class large enough for the request, or -1 when it is oversize.
    function automatic int class_for(int bytes);
        for (int c = 0; c < NUM_CLASSES; c++)
            if (bytes <= cell_size(c)) return c;
        return -1;
    endfunction

    // True when addr starts a live cell of a claimed slab; owner gives its class.
    function automatic bit is_live_cell(int addr, output int owner);
        int frame, csz, off;
        frame = addr / SLAB_BYTES;
        owner = -1;
        if (frame >= int'(frame_cnt)) return 0;
        owner = frame_owner[frame];
        csz   = cell_size(owner);
        off   = addr % SLAB_BYTES;
        if (off >= (SLAB_BYTES / csz) * csz || off % csz != 0) return 0;
        return live_bit[addr / GRANULE_BYTES];
    endfunction

    function automatic void set_live(int addr);
        if (!live_bit[addr / GRANULE_BYTES]) begin
            live_bit[addr / GRANULE_BYTES] = 1;
            live_count++;
        end
    endfunction

    // Applies one accepted request to the local state and queues the result.
    function automatic void run_request(logic [1:0] mode, logic [REG_W-1:0] bytes,
                                        logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        held_cell_t    h;
        int c, csz, owner, g, base;
        r = '0;
        c = class_for(int'(bytes));
        if (mode == MODE_ALLOC) begin
            if (c < 0) begin
                r.status = ST_OVERSIZE;
            end else if (head_ok[c]) begin
                r.granted    = head_addr[c];
                g            = head_addr[c] / GRANULE_BYTES;
                head_ok[c]   = link_ok[g];
                head_addr[c] = link_addr[g];
                set_live(r.granted);
                grant_count++;
            end else begin
                csz = cell_size(c);
                if (bump_ptr[c] >= bump_end[c] && frame_cnt >= MAX_FRAMES) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    if (bump_ptr[c] >= bump_end[c]) begin
                        base = int'(frame_cnt) * SLAB_BYTES;
                        frame_owner[frame_cnt] = CLASS_W'(c);
                        bump_ptr[c] = BADDR_W'(base);
                        bump_end[c] = BADDR_W'(base + (SLAB_BYTES / csz) * csz);
                        frame_cnt++;
                    end
                    r.granted   = bump_ptr[c][ADDR_W-1:0];
                    bump_ptr[c] = BADDR_W'(int'(bump_ptr[c]) + csz);
                    set_live(r.granted);
                    grant_count++;
                end
            end
        end else if (mode == MODE_FREE) begin
            if (c < 0) begin
                r.status = ST_OVERSIZE;
            end else if (is_live_cell(addr, owner) && owner == c) begin
                g = addr / GRANULE_BYTES;
                live_bit[g]  = 0;
                live_count--;
                link_ok[g]   = head_ok[c];
                link_addr[g] = head_addr[c];
                head_ok[c]   = 1;
                head_addr[c] = addr;
            end
        end else if (mode == MODE_QUERY) begin
            r.owned = is_live_cell(addr, owner);
        end
        r.live  = live_count;
        r.total = grant_count;
        pending_results = {pending_results, r};
        if (mode == MODE_ALLOC && r.status == ST_OK) begin
            h.addr  = r.granted;
            h.bytes = bytes;
            held_cells = {held_cells, h};
        end
    endfunction

    // Clock: period of 12.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: the stall rate is redrawn periodically; zero means no stalls.
    always @(negedge aclk) begin
        if (cycles % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_pct = 0;
                end
                1: begin
                    stall_pct = 25;
                end
                2: begin
                    stall_pct = 60;
                end
                default: begin
                    stall_pct = 90;
                end
            endcase
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker: each word taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tdata[1:0];
            got.granted = m_tdata[17:2];
            got.owned   = m_tdata[18];
            got.live    = m_tdata[32:19];
            got.total   = m_tdata[64:33];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h with nothing pending", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: status %0d/%0d granted %h/%h owned %0d/%0d ",
                                  "live %0d/%0d total %0d/%0d (expected/actual)"},
                                 want.status, got.status, want.granted, got.granted,
                                 want.owned, got.owned, want.live, got.live,
                                 want.total, got.total);
                end
            end
        end
    end

    // Sends one request word and updates the local state once it is accepted.
    // Called at a falling edge and returns at a falling edge. Valid stays high
    // through a burst and drops only when the burst ends.
    task automatic send_request(logic [1:0] mode, logic [REG_W-1:0] bytes,
                                logic [ADDR_W-1:0] addr);
        s_tdata  = {5'd0, addr, bytes, mode};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        run_request(mode, bytes, addr);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Holds the sender until every expected word has come back and the block
    // has had time to go quiet.
    task automatic drain;
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Writes all six size-class registers while the block is idle.
    task automatic write_sizes(input logic [REG_W-1:0] sizes [NUM_CLASSES]);
        drain();
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cfg_we    = 1'b1;
            cfg_index = IDX_W'(i);
            cfg_wdata = sizes[i];
            size_reg[i] = sizes[i];
            @(negedge aclk);
        end
        cfg_we = 1'b0;
    endtask

    // Allocates from every class at the reset geometry, once more from the smallest, then queries them.
    task automatic test_reset_classes;
        logic [REG_W-1:0] sz [6] = '{16, 32, 48, 64, 128, 256};
        foreach (sz[i]) send_request(MODE_ALLOC, sz[i], 16'h0000);
        send_request(MODE_ALLOC, 9'd1, 16'hFFFF);
        foreach (sz[i]) send_request(MODE_QUERY, 9'd0, 16'(i * SLAB_BYTES));
    endtask

    // Oversize requests, stray frees, misaligned and unclaimed queries, and
    // the unused mode code.
    task automatic test_error_cases;
        send_request(MODE_ALLOC, 9'd257, 16'h0000);
        send_request(MODE_ALLOC, 9'd511, 16'hFFFF);
        send_request(MODE_FREE,  9'd511, 16'h0000);
        send_request(MODE_FREE,  9'd16,  16'h0008);   // misaligned
        send_request(MODE_FREE,  9'd16,  16'hFC00);   // unclaimed frame
        send_request(MODE_FREE,  9'd200, 16'h0000);   // wrong class for the cell
        send_request(MODE_QUERY, 9'd0,   16'h0004);
        send_request(MODE_QUERY, 9'd0,   16'hFFFF);
        send_request(2'd3,       9'h1FF, 16'hFFFF);
    endtask

    // A freed cell goes onto its class list and is handed out again first.
    task automatic test_free_list_reuse;
        send_request(MODE_FREE,  9'd16, 16'h0000);
        send_request(MODE_FREE,  9'd16, 16'h0000);    // second free of a dead cell
        send_request(MODE_FREE,  9'd32, 16'h0400);
        send_request(MODE_QUERY, 9'd0,  16'h0000);
        send_request(MODE_ALLOC, 9'd9,  16'h0000);
        send_request(MODE_ALLOC, 9'd30, 16'h0000);
        send_request(MODE_QUERY, 9'd0,  16'h0400);
    endtask

    // Mostly well-formed traffic: allocations, frees of cells still held and queries
    // of held cells, with stray addresses, oversize sizes and the unused mode mixed in.
    task automatic test_random_traffic(int count);
        int roll, k;
        logic [ADDR_W-1:0] a;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_request(MODE_ALLOC, ($urandom_range(0, 19) == 0) ?
                             9'($urandom_range(257, 511)) : 9'($urandom_range(1, 256)),
                             16'($urandom));
            end else if (roll < 75) begin
                if (held_cells.size() != 0 && $urandom_range(0, 9) != 0) begin
                    k = $urandom_range(0, held_cells.size() - 1);
                    a = held_cells[k].addr;
                    send_request(MODE_FREE, held_cells[k].bytes, a);
                    held_cells.delete(k);
                end else begin
                    send_request(MODE_FREE, 9'($urandom_range(1, 511)), 16'($urandom));
                end
            end else if (roll < 92) begin
                if (held_cells.size() != 0 && $urandom_range(0, 3) != 0) begin
                    a = held_cells[$urandom_range(0, held_cells.size() - 1)].addr;
                    if ($urandom_range(0, 3) == 0) a = ADDR_W'(int'(a) + GRANULE_BYTES);
                    send_request(MODE_QUERY, 9'($urandom), a);
                end else begin
                    send_request(MODE_QUERY, 9'($urandom), 16'($urandom));
                end
            end else begin
                send_request(2'($urandom_range(2, 3)), 9'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        logic [REG_W-1:0] sizes [NUM_CLASSES];
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        mismatches = 0;
        burst_left = 4;

        for (int c = 0; c < NUM_CLASSES; c++) begin
            size_reg[c] = CLASS_RESET[c];
            head_ok[c]  = 1'b0;
            head_addr[c] = '0;
            bump_ptr[c] = '0;
            bump_end[c] = '0;
        end
        for (int f = 0; f < MAX_FRAMES; f++) frame_owner[f] = '0;
        for (int g = 0; g < GRANULES; g++) begin
            link_ok[g]   = 1'b0;
            link_addr[g] = '0;
            live_bit[g]  = 1'b0;
        end
        frame_cnt   = '0;
        live_count  = '0;
        grant_count = '0;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_classes();
        test_error_cases();
        test_free_list_reuse();
        test_random_traffic(250);

        // Smallest sizes, including registers below one granule and unaligned.
        sizes = '{9'd0, 9'd8, 9'd15, 9'd8, 9'd24, 9'd40};
        write_sizes(sizes);
        test_random_traffic(200);

        // Largest register values and an unsorted class order.
        sizes = '{9'd511, 9'd256, 9'd8, 9'd504, 9'd100, 9'd300};
        write_sizes(sizes);
        test_random_traffic(200);

        // Random granule-aligned and unaligned sizes.
        for (int i = 0; i < NUM_CLASSES; i++) sizes[i] = 9'($urandom_range(8, 256));
        write_sizes(sizes);
        test_random_traffic(200);

        // Back to the reset geometry for the last stretch.
        for (int i = 0; i < NUM_CLASSES; i++) sizes[i] = CLASS_RESET[i];
        write_sizes(sizes);
        test_random_traffic(180);

        drain();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
